>>> hdl/tpds_pkg.sv
package tpds_pkg;

   localparam int CLK_W  = 26;
   localparam int FREQ_W = 15;
   localparam int BASE_W = CLK_W - 1;
   localparam int GOT_W  = FREQ_W + 1;
   localparam int IDX_W  = 3;
   localparam int CMP_W  = 8;
   localparam int MAX_PRESCALERS = 6;

   localparam logic [CLK_W-1:0] CLOCK_RESET = 26'd16000000;

   // log2 of the prescaler divisors 2, 8, 32, 64, 128, 1024
   localparam logic [3:0] SHIFT_TABLE [0:7] = '{
      4'd1, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0
   };

   // clock select mask bytes
   localparam logic [7:0] SEL_TABLE [0:7] = '{
      8'h81, 8'h01, 8'h82, 8'h02, 8'h83, 8'h03, 8'h00, 8'h00
   };

   localparam int EXT_BIT = 7;

   typedef struct packed {
      logic              bad;
      logic [FREQ_W-1:0] freq;
      logic [BASE_W-1:0] base;
   } quo_side_type;

   typedef struct packed {
      logic              ok;
      logic [CMP_W-1:0]  cmp;
      logic [FREQ_W-1:0] freq;
   } got_side_type;

endpackage

>>> hdl/tpds_div_cell.sv
module tpds_div_cell #(
   parameter int RW = 25,
   parameter int VW = 16,
   parameter int QW = 8,
   parameter int SH = 0,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] rem,
   input  logic [QW-1:0] quo,
   input  logic [VW-1:0] dsr,
   input  logic [SW-1:0] side,
   output logic [RW-1:0] rem_q,
   output logic [QW-1:0] quo_q,
   output logic [VW-1:0] dsr_q,
   output logic [SW-1:0] side_q
);

   localparam int CW = (RW > VW + SH) ? RW : VW + SH;

   logic [CW-1:0] rem_w;
   logic [CW-1:0] sub_w;
   logic [CW-1:0] diff_w;
   logic          take;
   logic [RW-1:0] rem_in, rem_ff;
   logic [QW-1:0] quo_in, quo_ff;
   logic [VW-1:0] dsr_ff;
   logic [SW-1:0] side_ff;

   assign rem_w  = CW'(rem);
   assign sub_w  = CW'(dsr) << SH;
   assign take   = rem_w >= sub_w;
   assign diff_w = rem_w - sub_w;
   assign rem_in = take ? RW'(diff_w) : rem;
   assign quo_in = take ? (quo | (QW'(1) << SH)) : quo;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dsr_ff  <= dsr;
         side_ff <= side;
      end
   end

   assign rem_q  = rem_ff;
   assign quo_q  = quo_ff;
   assign dsr_q  = dsr_ff;
   assign side_q = side_ff;

endmodule

>>> hdl/tpds_lane.sv
module tpds_lane #(
   parameter int IDX   = 0,
   parameter int LIMIT = 256,
   parameter int QW    = 8,
   parameter int NS    = 24
) (
   input  logic                            clock,
   input  logic [NS-1:0]                   en,
   input  logic [tpds_pkg::CLK_W-1:0]      clk_hz,
   input  logic [tpds_pkg::FREQ_W-1:0]     freq,
   output logic                            ok,
   output logic [tpds_pkg::CMP_W-1:0]      cmp,
   output logic [tpds_pkg::FREQ_W-1:0]     err
);

   localparam int BW = tpds_pkg::BASE_W;
   localparam int GW = tpds_pkg::GOT_W;

   logic [BW-1:0]              base;
   logic [BW-1:0]              ovf_chk;
   tpds_pkg::quo_side_type     s1 [0:QW];
   logic [BW-1:0]              r1 [0:QW];
   logic [QW-1:0]              q1 [0:QW];
   logic [GW-1:0]              v1 [0:QW];
   tpds_pkg::got_side_type     s2 [0:GW];
   logic [BW-1:0]              r2 [0:GW];
   logic [GW-1:0]              q2 [0:GW];
   logic [QW:0]                v2 [0:GW];
   logic [QW-1:0]              n;

   assign base    = BW'(clk_hz >> tpds_pkg::SHIFT_TABLE[IDX]);
   assign ovf_chk = base >> (QW + 1);

   assign s1[0].bad  = (freq == '0) || (ovf_chk >= BW'(freq));
   assign s1[0].freq = freq;
   assign s1[0].base = base;
   assign r1[0]      = base;
   assign q1[0]      = '0;
   assign v1[0]      = {freq, 1'b0};

   for (genvar k = 0; k < QW; k++) begin : g_quo
      tpds_div_cell #(
         .RW(BW), .VW(GW), .QW(QW), .SH(QW - 1 - k), .SW($bits(tpds_pkg::quo_side_type))
      ) u_cell (
         .clock (clock),
         .en    (en[k]),
         .rem   (r1[k]),
         .quo   (q1[k]),
         .dsr   (v1[k]),
         .side  (s1[k]),
         .rem_q (r1[k+1]),
         .quo_q (q1[k+1]),
         .dsr_q (v1[k+1]),
         .side_q(s1[k+1])
      );
   end

   assign n = q1[QW];

   assign s2[0].ok   = !s1[QW].bad && (n != '0) && ({1'b0, n} < (QW + 1)'(LIMIT));
   assign s2[0].cmp  = tpds_pkg::CMP_W'(n);
   assign s2[0].freq = s1[QW].freq;
   assign r2[0]      = s1[QW].base;
   assign q2[0]      = '0;
   assign v2[0]      = {n, 1'b0};

   for (genvar k = 0; k < GW; k++) begin : g_got
      tpds_div_cell #(
         .RW(BW), .VW(QW + 1), .QW(GW), .SH(GW - 1 - k), .SW($bits(tpds_pkg::got_side_type))
      ) u_cell (
         .clock (clock),
         .en    (en[QW + k]),
         .rem   (r2[k]),
         .quo   (q2[k]),
         .dsr   (v2[k]),
         .side  (s2[k]),
         .rem_q (r2[k+1]),
         .quo_q (q2[k+1]),
         .dsr_q (v2[k+1]),
         .side_q(s2[k+1])
      );
   end

   assign ok  = s2[GW].ok;
   assign cmp = s2[GW].cmp;
   assign err = tpds_pkg::FREQ_W'(q2[GW] - {1'b0, s2[GW].freq});

endmodule

>>> hdl/tone_prescaler_divider_search_core.sv
// Tone prescaler search: each req beat carries a tone frequency and yields one rsp beat with
// the best timer prescaler, its compare value, mask bits and frequency error. A new beat is
// taken every cycle while the rsp side does not stall the pipeline; the path runs through
// two restoring dividers per prescaler lane, one quotient bit per cell, the first cell taking
// the request at the accepting edge; the selection sits in front of the output register, which
// holds the rsp beat until it is taken. main_clock_hz sits at csr address 0.
module tone_prescaler_divider_search_core #(
   parameter int PRESCALER_COUNT = 6,
   parameter int COMPARE_LIMIT   = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tpds_pkg::FREQ_W-1:0]        req_tone_freq,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [tpds_pkg::IDX_W-1:0]         rsp_prescaler_index,
   output logic [tpds_pkg::CMP_W-1:0]         rsp_compare_value,
   output logic                               rsp_extended_select,
   output logic [1:0]                         rsp_clock_select,
   output logic [tpds_pkg::FREQ_W-1:0]        rsp_freq_error,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int QW    = $clog2(COMPARE_LIMIT);
   localparam int NS    = QW + tpds_pkg::GOT_W;
   localparam int LANES = (PRESCALER_COUNT > tpds_pkg::MAX_PRESCALERS) ?
                          tpds_pkg::MAX_PRESCALERS : PRESCALER_COUNT;

   logic [tpds_pkg::CLK_W-1:0]  clk_hz_ff;
   logic [NS-1:0]               vld_ff;
   logic [NS-1:0]               en;
   logic                        out_en;

   logic                        ok  [0:LANES-1];
   logic [tpds_pkg::CMP_W-1:0]  cmp [0:LANES-1];
   logic [tpds_pkg::FREQ_W-1:0] err [0:LANES-1];

   logic                        have;
   logic [tpds_pkg::IDX_W-1:0]  best_idx;
   logic [tpds_pkg::CMP_W-1:0]  best_cmp;
   logic [tpds_pkg::FREQ_W-1:0] best_err;
   logic [7:0]                  sel;

   logic                        rsp_valid_ff;
   logic                        found_ff;
   logic [tpds_pkg::IDX_W-1:0]  idx_ff;
   logic [tpds_pkg::CMP_W-1:0]  cmp_ff;
   logic                        ext_ff;
   logic [1:0]                  cs_ff;
   logic [tpds_pkg::FREQ_W-1:0] err_ff;

   // config register
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= tpds_pkg::CLOCK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         clk_hz_ff <= csr_pwdata[tpds_pkg::CLK_W-1:0];
      end
   end
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(clk_hz_ff);

   // stage flow control, bubbles collapse
   assign out_en = !rsp_valid_ff || rsp_ready;
   always_comb begin
      for (int s = 0; s < NS; s++) begin
         if (s == NS - 1) begin
            en[s] = !vld_ff[s] || out_en;
         end else begin
            en[s] = !vld_ff[s] || en[s+1];
         end
      end
   end
   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               vld_ff[s] <= (s == 0) ? req_valid : vld_ff[s-1];
            end
         end
      end
   end

   for (genvar d = 0; d < LANES; d++) begin : g_lane
      tpds_lane #(.IDX(d), .LIMIT(COMPARE_LIMIT), .QW(QW), .NS(NS)) u_lane (
         .clock (clock),
         .en    (en),
         .clk_hz(clk_hz_ff),
         .freq  (req_tone_freq),
         .ok    (ok[d]),
         .cmp   (cmp[d]),
         .err   (err[d])
      );
   end

   // earliest lane with the smallest error
   always_comb begin
      have     = 1'b0;
      best_idx = '0;
      best_cmp = '0;
      best_err = '0;
      for (int d = 0; d < LANES; d++) begin
         if (ok[d] && (!have || err[d] < best_err)) begin
            have     = 1'b1;
            best_idx = tpds_pkg::IDX_W'(d);
            best_cmp = cmp[d];
            best_err = err[d];
         end
      end
   end
   assign sel = tpds_pkg::SEL_TABLE[best_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         found_ff <= have;
         idx_ff   <= best_idx;
         cmp_ff   <= best_cmp;
         ext_ff   <= have & sel[tpds_pkg::EXT_BIT];
         cs_ff    <= have ? sel[1:0] : 2'd0;
         err_ff   <= best_err;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_prescaler_index = idx_ff;
   assign rsp_compare_value   = cmp_ff;
   assign rsp_extended_select = ext_ff;
   assign rsp_clock_select    = cs_ff;
   assign rsp_freq_error      = err_ff;

endmodule

>>> hdl/tpds_checker.sv
module tpds_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [tpds_pkg::IDX_W-1:0]         rsp_prescaler_index,
   input logic [tpds_pkg::CMP_W-1:0]         rsp_compare_value,
   input logic                               rsp_extended_select,
   input logic [1:0]                         rsp_clock_select,
   input logic [tpds_pkg::FREQ_W-1:0]        rsp_freq_error,
   input logic                               csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_prescaler_index == '0 && rsp_compare_value == '0 &&
      !rsp_extended_select && rsp_clock_select == 2'd0 && rsp_freq_error == '0)
      else $error("not found beat carries nonzero fields");

   a_found_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_compare_value != '0 && rsp_clock_select != 2'd0 &&
      rsp_extended_select == !rsp_prescaler_index[0])
      else $error("found beat has inconsistent mask bits");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready low");

endmodule

bind tone_prescaler_divider_search_core tpds_checker u_tpds_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_found          (rsp_found),
   .rsp_prescaler_index(rsp_prescaler_index),
   .rsp_compare_value  (rsp_compare_value),
   .rsp_extended_select(rsp_extended_select),
   .rsp_clock_select   (rsp_clock_select),
   .rsp_freq_error     (rsp_freq_error),
   .csr_pready         (csr_pready)
);
